/* src/cbrf_pkg.sv */
// Shared types and constants for the cubic bisection root finder.
// No dependencies; imported by every module of the block.
`default_nettype none

package cbrf_pkg;

    localparam int X_W     = 24;
    localparam int TOL_W   = 24;
    localparam int CNT_W   = 16;
    localparam int VAL_W   = 41;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 24;

    // multiplier and cubic widths
    localparam int MUL_A_W = X_W + 1;
    localparam int PROD_W  = MUL_A_W + X_W;
    localparam int SQ_W    = 2 * X_W;
    localparam int CUBE_W  = PROD_W + X_W;
    localparam int F_W     = CUBE_W + 1;

    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER  = 8'd1;

    localparam logic [TOL_W-1:0] TOL_RESET  = 24'd66;
    localparam logic [CNT_W-1:0] ITER_RESET = 16'd100;

    localparam int CUBIC_OFFSET = 2;

    typedef enum logic [1:0] {
        ST_INVALID    = 2'd0,
        ST_SMALL_F    = 2'd1,
        ST_NARROW     = 2'd2,
        ST_ITER_LIMIT = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        SEL_LOWER,
        SEL_UPPER,
        SEL_MID
    } sel_t;

    typedef enum logic [2:0] {
        CP_IDLE,
        CP_SQUARE,
        CP_LOW,
        CP_HIGH,
        CP_SUM
    } cub_phase_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_A_START,
        S_A_WAIT,
        S_B_START,
        S_B_WAIT,
        S_CHECK,
        S_TEST,
        S_M_START,
        S_M_WAIT,
        S_DECIDE,
        S_R_START,
        S_R_WAIT,
        S_OUT
    } state_t;

    typedef struct packed {
        logic    load;
        logic    cub_start;
        sel_t    cub_sel;
        logic    latch_lower_sign;
        logic    latch_upper_sign;
        logic    init_loop;
        logic    set_mid;
        logic    step;
        logic    out_load;
        logic    out_invalid;
        status_t out_status;
    } cmd_t;

    typedef struct packed {
        logic cub_done;
        logic small_f;
        logic width_ok;
        logic iter_ok;
        logic opposite_ends;
        logic out_free;
    } stat_t;

endpackage

`default_nettype wire

/* src/cubic_bisection_root_finder_unit.sv */
// Bisection root finder for x^3 - x - 2, top level. One item at a time.
// Cubic evaluations run in sequence on the single shared multiplier, and a new item is
// taken only once the previous one has been loaded into the output register. An item is
// taken while the previous result waits.
// Reset: tolerance 66, step limit 100, output register empty, controller idle.
// Depends on cbrf_pkg, cbrf_ctrl, cbrf_datapath.
`default_nettype none

module cubic_bisection_root_finder_unit
    import cbrf_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic signed [X_W-1:0] s_left_end,
    input  wire logic signed [X_W-1:0] s_right_end,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [1:0]                 m_status,
    output logic signed [X_W-1:0]      m_root,
    output logic signed [VAL_W-1:0]    m_root_value,
    output logic [CNT_W-1:0]           m_iterations
);

    cmd_t  cmd;
    stat_t stat;

    cbrf_ctrl u_ctrl (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .stat   (stat),
        .cmd    (cmd)
    );

    cbrf_datapath #(
        .FRAC_BITS(FRAC_BITS)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .stat        (stat),
        .left_end    (s_left_end),
        .right_end   (s_right_end),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_status    (m_status),
        .m_root      (m_root),
        .m_root_value(m_root_value),
        .m_iterations(m_iterations)
    );

endmodule

`default_nettype wire

/* src/cbrf_cubic.sv */
// Multi-cycle evaluator of x^3 - x - 2 in fixed point, one shared multiplier.
// Depends on cbrf_pkg.
`default_nettype none

module cbrf_cubic
    import cbrf_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  start,
    input  wire logic signed [X_W-1:0] x_in,
    output logic                       done,
    output logic signed [F_W-1:0]      f_out
);

    localparam logic signed [F_W-1:0] OFFSET_FIX =
        F_W'(CUBIC_OFFSET) << FRAC_BITS;

    cub_phase_t phase_reg, phase_next;
    logic done_reg;
    logic signed [X_W-1:0]    x_reg;
    logic signed [SQ_W-1:0]   sq_reg;
    logic signed [PROD_W-1:0] plo_reg;
    logic signed [PROD_W-1:0] phi_reg;
    logic signed [F_W-1:0]    f_reg, f_next;

    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [PROD_W-1:0]  prod;
    logic signed [CUBE_W-1:0]  cube;
    logic signed [CUBE_W-1:0]  cu;

    always_comb begin
        phase_next = phase_reg;
        unique case (phase_reg)
            CP_IDLE:   if (start) phase_next = CP_SQUARE;
            CP_SQUARE: phase_next = CP_LOW;
            CP_LOW:    phase_next = CP_HIGH;
            CP_HIGH:   phase_next = CP_SUM;
            CP_SUM:    phase_next = CP_IDLE;
            default:   phase_next = CP_IDLE;
        endcase
    end

    always_comb begin
        unique case (phase_reg)
            CP_SQUARE: mul_a = {x_reg[X_W-1], x_reg};
            CP_LOW:    mul_a = {1'b0, sq_reg[X_W-1:0]};
            CP_HIGH:   mul_a = {1'b0, sq_reg[SQ_W-1:X_W]};
            default:   mul_a = '0;
        endcase
    end

    assign prod = mul_a * x_reg;

    always_comb begin
        cube   = $signed({phi_reg, {X_W{1'b0}}})
               + $signed({{X_W{plo_reg[PROD_W-1]}}, plo_reg});
        cu     = cube >>> FRAC_BITS;
        f_next = $signed({cu[CUBE_W-1], cu})
               - $signed({{(F_W-X_W){x_reg[X_W-1]}}, x_reg})
               - OFFSET_FIX;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= CP_IDLE;
            done_reg  <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            done_reg  <= (phase_reg == CP_SUM);
        end
    end

    always_ff @(posedge aclk) begin
        if (phase_reg == CP_IDLE && start) x_reg <= x_in;
        if (phase_reg == CP_SQUARE) sq_reg <= SQ_W'(prod >>> FRAC_BITS);
        if (phase_reg == CP_LOW) plo_reg <= prod;
        if (phase_reg == CP_HIGH) phi_reg <= prod;
        if (phase_reg == CP_SUM) f_reg <= f_next;
    end

    assign done  = done_reg;
    assign f_out = f_reg;

endmodule

`default_nettype wire

/* src/cbrf_datapath.sv */
// Datapath: bounds, midpoint, step count, config and result registers.
// Depends on cbrf_pkg and cbrf_cubic.
`default_nettype none

module cbrf_datapath
    import cbrf_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire cmd_t                   cmd,
    output stat_t                       stat,
    input  wire logic signed [X_W-1:0]  left_end,
    input  wire logic signed [X_W-1:0]  right_end,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output logic [1:0]                  m_status,
    output logic signed [X_W-1:0]       m_root,
    output logic signed [VAL_W-1:0]     m_root_value,
    output logic [CNT_W-1:0]            m_iterations
);

    logic [TOL_W-1:0] tol_reg;
    logic [CNT_W-1:0] max_iter_reg;

    logic signed [X_W-1:0] lower_reg, upper_reg, mid_reg;
    logic [1:0] lower_sign_reg;  // {pos, neg}
    logic [1:0] upper_sign_reg;
    logic [CNT_W-1:0] count_reg;

    logic out_valid_reg;
    logic [1:0] out_status_reg;
    logic signed [X_W-1:0] out_root_reg;
    logic signed [VAL_W-1:0] out_value_reg;
    logic [CNT_W-1:0] out_iter_reg;

    logic signed [X_W-1:0] cub_x;
    logic cub_done;
    logic signed [F_W-1:0] f_val;
    logic [1:0] f_sign;
    logic signed [F_W-1:0] tol_f;
    logic signed [X_W:0] bound_sum;
    logic signed [X_W+1:0] width;
    logic f_opposite;

    cbrf_cubic #(
        .FRAC_BITS(FRAC_BITS)
    ) u_cubic (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (cmd.cub_start),
        .x_in   (cub_x),
        .done   (cub_done),
        .f_out  (f_val)
    );

    always_comb begin
        unique case (cmd.cub_sel)
            SEL_LOWER: cub_x = lower_reg;
            SEL_UPPER: cub_x = upper_reg;
            SEL_MID:   cub_x = mid_reg;
            default:   cub_x = mid_reg;
        endcase
    end

    always_comb begin
        f_sign[1]  = !f_val[F_W-1] && (f_val != '0);
        f_sign[0]  = f_val[F_W-1];
        tol_f      = $signed({{(F_W-TOL_W){1'b0}}, tol_reg});
        bound_sum  = $signed({lower_reg[X_W-1], lower_reg})
                   + $signed({upper_reg[X_W-1], upper_reg});
        width      = $signed({{2{upper_reg[X_W-1]}}, upper_reg})
                   - $signed({{2{lower_reg[X_W-1]}}, lower_reg});
        f_opposite = (lower_sign_reg[1] && f_sign[0]) || (lower_sign_reg[0] && f_sign[1]);
    end

    always_comb begin
        stat.cub_done      = cub_done;
        stat.small_f       = (f_val < tol_f) && (f_val > -tol_f);
        stat.width_ok      = width >= $signed({2'b00, tol_reg});
        stat.iter_ok       = count_reg < max_iter_reg;
        stat.opposite_ends = (lower_sign_reg[1] && upper_sign_reg[0])
                          || (lower_sign_reg[0] && upper_sign_reg[1]);
        stat.out_free      = !out_valid_reg || m_ready;
    end

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tol_reg      <= TOL_RESET;
            max_iter_reg <= ITER_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_TOLERANCE: tol_reg      <= cfg_data;
                CFG_MAX_ITER:  max_iter_reg <= cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            lower_reg <= left_end;
            upper_reg <= right_end;
            mid_reg   <= left_end;
        end
        if (cmd.latch_lower_sign) lower_sign_reg <= f_sign;
        if (cmd.latch_upper_sign) upper_sign_reg <= f_sign;
        if (cmd.init_loop) count_reg <= '0;
        if (cmd.set_mid) mid_reg <= bound_sum[X_W:1];
        if (cmd.step) begin
            if (f_opposite) begin
                upper_reg <= mid_reg;
            end else begin
                lower_reg      <= mid_reg;
                lower_sign_reg <= f_sign;
            end
            count_reg <= count_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            if (cmd.out_invalid) begin
                out_status_reg <= ST_INVALID;
                out_root_reg   <= '0;
                out_value_reg  <= '0;
                out_iter_reg   <= '0;
            end else begin
                out_status_reg <= cmd.out_status;
                out_root_reg   <= mid_reg;
                out_value_reg  <= f_val[VAL_W-1:0];
                out_iter_reg   <= count_reg;
            end
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_status     = out_status_reg;
    assign m_root       = out_root_reg;
    assign m_root_value = out_value_reg;
    assign m_iterations = out_iter_reg;

endmodule

`default_nettype wire

/* src/cbrf_ctrl.sv */
// Controller state machine sequencing end checks, bisection steps and output.
// Depends on cbrf_pkg.
`default_nettype none

module cbrf_ctrl
    import cbrf_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  s_valid,
    output logic       s_ready,
    input  wire stat_t stat,
    output cmd_t       cmd
);

    state_t  state_reg, state_next;
    status_t status_reg, status_next;
    logic    invalid_reg, invalid_next;

    always_comb begin
        state_next   = state_reg;
        status_next  = status_reg;
        invalid_next = invalid_reg;
        unique case (state_reg)
            S_IDLE:    if (s_valid) state_next = S_A_START;
            S_A_START: state_next = S_A_WAIT;
            S_A_WAIT:  if (stat.cub_done) state_next = S_B_START;
            S_B_START: state_next = S_B_WAIT;
            S_B_WAIT:  if (stat.cub_done) state_next = S_CHECK;
            S_CHECK: begin
                invalid_next = !stat.opposite_ends;
                state_next   = stat.opposite_ends ? S_TEST : S_OUT;
            end
            S_TEST: begin
                if (stat.width_ok && stat.iter_ok) begin
                    state_next = S_M_START;
                end else begin
                    status_next = stat.width_ok ? ST_ITER_LIMIT : ST_NARROW;
                    state_next  = S_R_START;
                end
            end
            S_M_START: state_next = S_M_WAIT;
            S_M_WAIT:  if (stat.cub_done) state_next = S_DECIDE;
            S_DECIDE: begin
                if (stat.small_f) begin
                    status_next = ST_SMALL_F;
                    state_next  = S_OUT;
                end else begin
                    state_next = S_TEST;
                end
            end
            S_R_START: state_next = S_R_WAIT;
            S_R_WAIT:  if (stat.cub_done) state_next = S_OUT;
            S_OUT:     if (stat.out_free) state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    always_comb begin
        cmd            = '0;
        cmd.cub_sel    = SEL_MID;
        cmd.out_status = status_reg;
        cmd.out_invalid = invalid_reg;
        s_ready        = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            S_A_START: begin
                cmd.cub_start = 1'b1;
                cmd.cub_sel   = SEL_LOWER;
            end
            S_A_WAIT: cmd.latch_lower_sign = stat.cub_done;
            S_B_START: begin
                cmd.cub_start = 1'b1;
                cmd.cub_sel   = SEL_UPPER;
            end
            S_B_WAIT:  cmd.latch_upper_sign = stat.cub_done;
            S_CHECK:   cmd.init_loop = 1'b1;
            S_TEST:    cmd.set_mid = stat.width_ok && stat.iter_ok;
            S_M_START: cmd.cub_start = 1'b1;
            S_DECIDE:  cmd.step = !stat.small_f;
            S_R_START: cmd.cub_start = 1'b1;
            S_OUT:     cmd.out_load = stat.out_free;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            status_reg  <= ST_INVALID;
            invalid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            status_reg  <= status_next;
            invalid_reg <= invalid_next;
        end
    end

endmodule

`default_nettype wire
